// ===== sv/pru_pkg.sv =====
// pru_pkg: shared types and constants for the pixel replicate upscaler
// no dependencies; used by pru_ctrl, pru_out and the top level by scoped names

package pru_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int COL_W       = 11;
  localparam int SCALE_W     = 7;
  localparam int PIXEL_W     = 24;
  localparam int PAD_W       = 2;
  localparam int SCALE_LIMIT = 100;
  localparam int OUT_DATA_W  = 40;

  // input kinds carried in tuser
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // result status carried in tuser
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // configuration register indexes
  localparam logic REG_SCALE     = 1'b0;
  localparam logic REG_SRC_WIDTH = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               from_ram;
    logic [SCALE_W-1:0] repeat_res;
    logic [PAD_W-1:0]   pad_bytes;
    logic               row_end;
    logic               status;
  } run_t;

endpackage

// ===== sv/pru_ram.sv =====
// pru_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies

module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pru_ctrl.sv =====
// pru_ctrl: configuration registers, column counters and replay count
// depends on pru_pkg; drives the row buffer ram and hands at most one run per transaction

module pru_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [pru_pkg::COL_W-1:0]   cfg_data,
  input  logic                        accept,
  input  logic                        kind,
  input  logic [pru_pkg::PIXEL_W-1:0] pixel,
  output logic                        res_valid,
  output pru_pkg::run_t               res,
  output logic                        ram_we,
  output logic [pru_pkg::ADDR_W-1:0]  ram_waddr,
  output logic [pru_pkg::PIXEL_W-1:0] ram_wdata,
  output logic                        ram_re,
  output logic [pru_pkg::ADDR_W-1:0]  ram_raddr
);

  logic [pru_pkg::SCALE_W-1:0] scale;
  logic [pru_pkg::COL_W-1:0]   src_width;
  logic [pru_pkg::COL_W-1:0]   write_column;
  logic [pru_pkg::COL_W-1:0]   replay_column;
  logic [pru_pkg::SCALE_W-1:0] replays_left;

  logic [pru_pkg::SCALE_W-1:0] eff_scale;
  logic [pru_pkg::COL_W-1:0]   eff_width;
  logic [pru_pkg::COL_W-1:0]   last_col;
  logic [pru_pkg::PAD_W-1:0]   row_bytes_lo;
  logic [pru_pkg::PAD_W-1:0]   row_pad;
  logic                        write_end;
  logic                        replay_end;
  logic                        pending;

  always_comb begin
    if (scale == '0) begin
      eff_scale = pru_pkg::SCALE_W'(1);
    end else if (scale > pru_pkg::SCALE_W'(pru_pkg::SCALE_LIMIT)) begin
      eff_scale = pru_pkg::SCALE_W'(pru_pkg::SCALE_LIMIT);
    end else begin
      eff_scale = scale;
    end
    if (src_width == '0) begin
      eff_width = pru_pkg::COL_W'(1);
    end else if (src_width > pru_pkg::COL_W'(pru_pkg::MAX_WIDTH)) begin
      eff_width = pru_pkg::COL_W'(pru_pkg::MAX_WIDTH);
    end else begin
      eff_width = src_width;
    end
  end

  assign last_col = eff_width - pru_pkg::COL_W'(1);
  // bytes per row mod 4 only needs the low two bits of each factor
  assign row_bytes_lo = pru_pkg::PAD_W'(eff_width[1:0] * eff_scale[1:0] * 2'd3);
  assign row_pad      = pru_pkg::PAD_W'(-row_bytes_lo);
  assign write_end    = write_column >= last_col;
  assign replay_end   = replay_column >= last_col;
  assign pending      = replays_left != '0;

  always_comb begin
    res_valid      = 1'b0;
    res.pixel      = pixel;
    res.from_ram   = 1'b0;
    res.repeat_res = eff_scale;
    res.pad_bytes  = '0;
    res.row_end    = 1'b0;
    res.status     = pru_pkg::STATUS_OK;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = write_column[pru_pkg::ADDR_W-1:0];
    ram_wdata      = pixel;
    ram_raddr      = replay_column[pru_pkg::ADDR_W-1:0];
    case (kind)
      pru_pkg::KIND_PIXEL: begin
        res_valid = 1'b1;
        if (pending) begin
          res.pixel      = '0;
          res.repeat_res = '0;
          res.status     = pru_pkg::STATUS_REFUSED;
        end else begin
          ram_we      = accept;
          res.row_end = write_end;
          res.pad_bytes = write_end ? row_pad : '0;
        end
      end
      pru_pkg::KIND_TICK: begin
        res_valid = pending;
        ram_re    = accept && pending;
        res.from_ram  = 1'b1;
        res.row_end   = replay_end;
        res.pad_bytes = replay_end ? row_pad : '0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale         <= pru_pkg::SCALE_W'(1);
      src_width     <= pru_pkg::COL_W'(1);
      write_column  <= '0;
      replay_column <= '0;
      replays_left  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pru_pkg::REG_SCALE:     scale <= cfg_data[pru_pkg::SCALE_W-1:0];
          pru_pkg::REG_SRC_WIDTH: src_width <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (kind == pru_pkg::KIND_PIXEL) begin
          if (!pending) begin
            if (write_end) begin
              write_column  <= '0;
              replay_column <= '0;
              replays_left  <= eff_scale - pru_pkg::SCALE_W'(1);
            end else begin
              write_column <= write_column + pru_pkg::COL_W'(1);
            end
          end
        end else if (pending) begin
          if (replay_end) begin
            replay_column <= '0;
            replays_left  <= replays_left - pru_pkg::SCALE_W'(1);
          end else begin
            replay_column <= replay_column + pru_pkg::COL_W'(1);
          end
        end
      end
    end
  end

endmodule

// ===== sv/pru_out.sv =====
// pru_out: ram read stage and output register with stall handling
// depends on pru_pkg; takes runs from pru_ctrl and read data from pru_ram

module pru_out (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           res_valid,
  input  pru_pkg::run_t                  res,
  input  logic [pru_pkg::PIXEL_W-1:0]    ram_rdata,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pru_pkg::OUT_DATA_W-1:0] out_data,
  output logic                           out_last,
  output logic                           out_user
);

  logic          s1_valid;
  pru_pkg::run_t s1;
  logic          out_free;

  logic [pru_pkg::PIXEL_W-1:0] s1_pixel;
  logic [pru_pkg::SCALE_W-1:0] o_repeat;
  logic [pru_pkg::PAD_W-1:0]   o_pad;
  logic [pru_pkg::PIXEL_W-1:0] o_pixel;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_free;
  // ram data holds while no read is issued, so a stalled stage keeps it
  assign s1_pixel = s1.from_ram ? ram_rdata : s1.pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (in_ready) begin
        s1_valid <= accept && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1 <= res;
    end
    if (out_free) begin
      o_pixel  <= s1_pixel;
      o_repeat <= s1.repeat_res;
      o_pad    <= s1.pad_bytes;
      out_last <= s1.row_end;
      out_user <= s1.status;
    end
  end

  assign out_data = {
    (pru_pkg::OUT_DATA_W - pru_pkg::PIXEL_W - pru_pkg::SCALE_W - pru_pkg::PAD_W)'(0),
    o_pad, o_repeat, o_pixel
  };

endmodule

// ===== sv/pixel_replicate_upscaler.sv =====
// pixel_replicate_upscaler: top level of the integer nearest-neighbour upscaler
// depends on pru_pkg, pru_ram, pru_ctrl and pru_out
//
// usage
// - input stream: one transaction per source pixel (tuser low) or per replay
//   tick (tuser high); tdata carries the pixel, ignored for ticks
// - every pixel yields one run at once (repeat = scale); after the last pixel
//   of a row, scale-1 replays of the stored row are pending and each tick
//   yields one run of the stored row in column order
// - the run that closes an output row raises tlast and carries the number of
//   zero bytes that pad the output row to a multiple of four bytes
// - a pixel offered while replays are pending is refused: tuser high on the
//   result, all other fields zero; a tick with nothing pending gives no result
// - configuration: cfg_we writes register cfg_index (0 scale, 1 src_width);
//   write only while the block is idle
// - pipeline: each result passes through the row buffer ram read stage and then
//   the output register on its way to the output port
// - throughput: one transaction per cycle while the receiver does not stall,
//   bound by the single write and read port of the row buffer ram
// - reset clears scale and src_width to 1, the column counters and the
//   replay count; the row buffer contents are not cleared
// - when the receiver stalls, the output register and the read stage hold;
//   s_axis_tready drops only when both are full

module pixel_replicate_upscaler (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [pru_pkg::COL_W-1:0]      cfg_data,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pru_pkg::PIXEL_W-1:0]    s_axis_tdata,  // pixel[23:0]
  input  logic                           s_axis_tuser,  // kind
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // run_pixel[23:0], repeat_res[30:24], pad_bytes[32:31], zeros[39:33]
  output logic [pru_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,  // row_end
  output logic                           m_axis_tuser   // status
);

  logic                        accept;
  logic                        res_valid;
  pru_pkg::run_t               res;
  logic                        ram_we;
  logic [pru_pkg::ADDR_W-1:0]  ram_waddr;
  logic [pru_pkg::PIXEL_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [pru_pkg::ADDR_W-1:0]  ram_raddr;
  logic [pru_pkg::PIXEL_W-1:0] ram_rdata;

  // an input transaction completes on valid and ready together
  assign accept = s_axis_tvalid && s_axis_tready;

  pru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (s_axis_tuser),
    .pixel     (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // row buffer: one source row of pixels
  pru_ram #(
    .WIDTH (pru_pkg::PIXEL_W),
    .DEPTH (pru_pkg::MAX_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pru_out u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .res_valid (res_valid),
    .res       (res),
    .ram_rdata (ram_rdata),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_user  (m_axis_tuser)
  );

endmodule

// ===== sim/pru_run_checker.sv =====
// pru_run_checker: scoreboard for the pixel replicate upscaler, predicts every run
// from the observed configuration writes and input transactions and compares results
// depends on pru_pkg for widths, kinds, status codes and register indexes
`timescale 1ns / 1ps

module pru_run_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [pru_pkg::COL_W-1:0]      cfg_data,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [pru_pkg::PIXEL_W-1:0]    s_axis_tdata,  // pixel[23:0]
  input  logic                           s_axis_tuser,  // kind
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // run_pixel[23:0], repeat_res[30:24], pad_bytes[32:31], zeros[39:33]
  input  logic [pru_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tlast,  // row_end
  input  logic                           m_axis_tuser,  // status
  output int                             fail_count,
  output int                             runs_outstanding,
  output logic                           replay_pending,
  output int                             stored_extent
);

  localparam int REPEAT_LSB      = pru_pkg::PIXEL_W;
  localparam int PAD_LSB         = REPEAT_LSB + pru_pkg::SCALE_W;
  localparam int USED_BITS       = PAD_LSB + pru_pkg::PAD_W;
  localparam int ROW_ALIGN       = 4;
  localparam int BYTES_PER_PIXEL = 3;
  localparam int MAX_PRINTED     = 40;

  typedef struct packed {
    logic [pru_pkg::PIXEL_W-1:0] run_pixel;
    logic [pru_pkg::SCALE_W-1:0] repeat_res;
    logic [pru_pkg::PAD_W-1:0]   pad_bytes;
    logic                        row_end;
    logic                        status;
  } upscale_run_t;

  logic [pru_pkg::SCALE_W-1:0] scale_reg;
  logic [pru_pkg::COL_W-1:0]   width_reg;
  logic [pru_pkg::PIXEL_W-1:0] row_buf [pru_pkg::MAX_WIDTH];
  int                          write_col;
  int                          replay_col;
  int                          replays_left;
  upscale_run_t                expected_runs [$];

  function automatic int current_scale();
    if (scale_reg == 0) return 1;
    if (scale_reg > pru_pkg::SCALE_LIMIT) return pru_pkg::SCALE_LIMIT;
    return int'(scale_reg);
  endfunction

  function automatic int current_width();
    if (width_reg == 0) return 1;
    if (width_reg > pru_pkg::MAX_WIDTH) return pru_pkg::MAX_WIDTH;
    return int'(width_reg);
  endfunction

  // zero bytes that bring width*scale pixels of three bytes to a whole word
  function automatic int row_padding();
    int row_bytes;
    row_bytes = current_width() * current_scale() * BYTES_PER_PIXEL;
    return (ROW_ALIGN - (row_bytes % ROW_ALIGN)) % ROW_ALIGN;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    if (fail_count < MAX_PRINTED)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    fail_count++;
  endtask

  task automatic predict_run(input logic kind, input logic [pru_pkg::PIXEL_W-1:0] px);
    upscale_run_t run;
    int           last_col;
    logic         closes;
    run      = '0;
    last_col = current_width() - 1;
    if (kind == pru_pkg::KIND_PIXEL) begin
      if (replays_left != 0) begin
        run.status = pru_pkg::STATUS_REFUSED;
        expected_runs.push_back(run);
      end else begin
        if (write_col < pru_pkg::MAX_WIDTH) row_buf[write_col] = px;
        if (write_col + 1 > stored_extent) stored_extent = write_col + 1;
        closes         = (write_col >= last_col);
        run.run_pixel  = px;
        run.repeat_res = pru_pkg::SCALE_W'(current_scale());
        run.pad_bytes  = closes ? pru_pkg::PAD_W'(row_padding()) : '0;
        run.row_end    = closes;
        run.status     = pru_pkg::STATUS_OK;
        expected_runs.push_back(run);
        if (closes) begin
          write_col    = 0;
          replay_col   = 0;
          replays_left = current_scale() - 1;
        end else begin
          write_col++;
        end
      end
    end else if (replays_left != 0) begin
      closes         = (replay_col >= last_col);
      run.run_pixel  = (replay_col < pru_pkg::MAX_WIDTH) ? row_buf[replay_col] : '0;
      run.repeat_res = pru_pkg::SCALE_W'(current_scale());
      run.pad_bytes  = closes ? pru_pkg::PAD_W'(row_padding()) : '0;
      run.row_end    = closes;
      run.status     = pru_pkg::STATUS_OK;
      expected_runs.push_back(run);
      if (closes) begin
        replay_col = 0;
        replays_left--;
      end else begin
        replay_col++;
      end
    end
  endtask

  task automatic check_run();
    upscale_run_t want;
    if (expected_runs.size() == 0) begin
      report_mismatch("run with nothing expected", 64'(0), 64'(m_axis_tdata));
    end else begin
      want = expected_runs.pop_front();
      if (m_axis_tdata[REPEAT_LSB-1:0] !== want.run_pixel)
        report_mismatch("run_pixel", 64'(want.run_pixel),
                        64'(m_axis_tdata[REPEAT_LSB-1:0]));
      if (m_axis_tdata[PAD_LSB-1:REPEAT_LSB] !== want.repeat_res)
        report_mismatch("repeat_res", 64'(want.repeat_res),
                        64'(m_axis_tdata[PAD_LSB-1:REPEAT_LSB]));
      if (m_axis_tdata[USED_BITS-1:PAD_LSB] !== want.pad_bytes)
        report_mismatch("pad_bytes", 64'(want.pad_bytes),
                        64'(m_axis_tdata[USED_BITS-1:PAD_LSB]));
      if (m_axis_tdata[pru_pkg::OUT_DATA_W-1:USED_BITS] !== '0)
        report_mismatch("tdata fill bits", 64'(0),
                        64'(m_axis_tdata[pru_pkg::OUT_DATA_W-1:USED_BITS]));
      if (m_axis_tlast !== want.row_end)
        report_mismatch("row_end", 64'(want.row_end), 64'(m_axis_tlast));
      if (m_axis_tuser !== want.status)
        report_mismatch("status", 64'(want.status), 64'(m_axis_tuser));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scale_reg     = 1;
      width_reg     = 1;
      write_col     = 0;
      replay_col    = 0;
      replays_left  = 0;
      stored_extent = 0;
      fail_count    = 0;
      expected_runs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == pru_pkg::REG_SCALE) scale_reg = cfg_data[pru_pkg::SCALE_W-1:0];
        else width_reg = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) predict_run(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_run();
    end
    runs_outstanding = expected_runs.size();
    replay_pending   = (replays_left != 0);
  end

endmodule

// ===== sim/tb_pixel_replicate_upscaler.sv =====
// tb_pixel_replicate_upscaler: stimulus and verdict for the pixel replicate upscaler,
// directed rows first, then random rows with bursty input and a patterned stalling receiver
// depends on pru_pkg, pixel_replicate_upscaler and pru_run_checker
`timescale 1ns / 1ps

module tb_pixel_replicate_upscaler;

  localparam int CLOCK_HALF    = 5;
  localparam int RESET_CYCLES  = 7;
  // two stage pipeline plus some margin; ticks with nothing pending leave no result
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 950;
  // keep random rows short when the scale is large
  localparam int ROW_COST_CAP  = 200;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_DUTY} rx_mode_t;

  logic                           clk           = 1'b0;
  logic                           rst           = 1'b1;
  logic                           cfg_we        = 1'b0;
  logic                           cfg_index     = pru_pkg::REG_SCALE;
  logic [pru_pkg::COL_W-1:0]      cfg_data      = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [pru_pkg::PIXEL_W-1:0]    s_axis_tdata  = '0;
  logic                           s_axis_tuser  = pru_pkg::KIND_PIXEL;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b1;
  logic [pru_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           m_axis_tuser;

  // scoreboard feedback
  int   fail_count;
  int   runs_outstanding;
  logic replay_pending;
  int   stored_extent;

  // stimulus bookkeeping
  int                        burst_left  = 0;
  int                        items_sent  = 0;
  int                        cycle_count = 0;
  logic [pru_pkg::COL_W-1:0] scale_now   = 1;
  logic [pru_pkg::COL_W-1:0] width_now   = 1;

  // receiver stall pattern state
  rx_mode_t rx_mode      = RX_ALWAYS;
  int       pattern_left = 0;
  int       duty_on      = 1;
  int       duty_off     = 1;
  int       duty_phase   = 0;

  pixel_replicate_upscaler dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  pru_run_checker run_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .m_axis_tuser     (m_axis_tuser),
    .fail_count       (fail_count),
    .runs_outstanding (runs_outstanding),
    .replay_pending   (replay_pending),
    .stored_extent    (stored_extent)
  );

  always begin
    #CLOCK_HALF clk = 1'b1;
    #CLOCK_HALF clk = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: switches between always ready, random stalls and a fixed duty cycle,
  // each held for a random stretch
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(2, 0));
      pattern_left = $urandom_range(300, 40);
      duty_on      = $urandom_range(6, 1);
      duty_off     = $urandom_range(5, 1);
    end else begin
      pattern_left--;
    end
    duty_phase = (duty_phase + 1) % (duty_on + duty_off);
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= ($urandom_range(2, 0) != 0);
      default:   m_axis_tready <= (duty_phase < duty_on);
    endcase
  end

  // register values as the block sees them, only used to shape the stimulus
  function automatic int scale_in_use(input logic [pru_pkg::COL_W-1:0] value);
    if (value[pru_pkg::SCALE_W-1:0] == 0) return 1;
    if (value[pru_pkg::SCALE_W-1:0] > pru_pkg::SCALE_LIMIT) return pru_pkg::SCALE_LIMIT;
    return int'(value[pru_pkg::SCALE_W-1:0]);
  endfunction

  function automatic int width_in_use(input logic [pru_pkg::COL_W-1:0] value);
    if (value == 0) return 1;
    if (value > pru_pkg::MAX_WIDTH) return pru_pkg::MAX_WIDTH;
    return int'(value);
  endfunction

  function automatic logic [pru_pkg::PIXEL_W-1:0] random_pixel();
    logic [pru_pkg::PIXEL_W-1:0] px;
    case ($urandom_range(15, 0))
      0:       px = '0;
      1:       px = '1;
      default: px = pru_pkg::PIXEL_W'($urandom());
    endcase
    return px;
  endfunction

  function automatic logic [pru_pkg::COL_W-1:0] pick_scale();
    case ($urandom_range(9, 0))
      0:       return 0;
      1:       return pru_pkg::COL_W'($urandom_range(12, 5));
      2:       return pru_pkg::COL_W'(($urandom_range(1, 0) != 0) ? 100
                                      : $urandom_range(127, 101));
      default: return pru_pkg::COL_W'($urandom_range(4, 1));
    endcase
  endfunction

  function automatic logic [pru_pkg::COL_W-1:0] pick_width();
    case ($urandom_range(9, 0))
      0:       return 0;
      1, 2:    return pru_pkg::COL_W'($urandom_range(40, 9));
      default: return pru_pkg::COL_W'($urandom_range(8, 1));
    endcase
  endfunction

  // all tasks are entered and left at a falling edge; one transaction on the input
  // stream, with tvalid kept high across a burst and dropped for the gap after it
  task automatic send_item(input logic kind, input logic [pru_pkg::PIXEL_W-1:0] px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // hold the input until every expected run is out and the pipeline has drained
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (runs_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_register(input logic index,
                                  input logic [pru_pkg::COL_W-1:0] value);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index == pru_pkg::REG_SCALE) scale_now = value;
    else width_now = value;
  endtask

  task automatic drain_replays();
    while (replay_pending) send_item(pru_pkg::KIND_TICK, random_pixel());
  endtask

  // a wider row during a pending replay would read columns never written,
  // so finish the replay first in that case
  task automatic set_width(input logic [pru_pkg::COL_W-1:0] value);
    if (replay_pending && width_in_use(value) > stored_extent) drain_replays();
    program_register(pru_pkg::REG_SRC_WIDTH, value);
  endtask

  task automatic tweak_register();
    if ($urandom_range(1, 0) == 0)
      program_register(pru_pkg::REG_SCALE, pru_pkg::COL_W'($urandom_range(6, 0)));
    else set_width(pru_pkg::COL_W'($urandom_range(10, 0)));
  endtask

  // one source row and its replays, with stray ticks, refused pixels,
  // register changes mid-row and the odd abandoned replay mixed in
  task automatic upscale_row();
    int cols;
    cols = width_in_use(width_now);
    for (int col = 0; col < cols; col++) begin
      if ($urandom_range(99, 0) < 4) send_item(pru_pkg::KIND_TICK, random_pixel());
      if ($urandom_range(99, 0) < 3) tweak_register();
      send_item(pru_pkg::KIND_PIXEL, random_pixel());
    end
    while (replay_pending) begin
      // leave the replay pending so the next row starts with refused pixels
      if ($urandom_range(99, 0) < 2) break;
      if ($urandom_range(99, 0) < 5) send_item(pru_pkg::KIND_PIXEL, random_pixel());
      else send_item(pru_pkg::KIND_TICK, random_pixel());
    end
    if ($urandom_range(99, 0) < 5) send_item(pru_pkg::KIND_TICK, random_pixel());
    if ($urandom_range(99, 0) < 6) wait_for_results();
  endtask

  initial begin
    int                        random_target;
    logic [pru_pkg::COL_W-1:0] next_width;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset values, one pixel per row, no replays
    send_item(pru_pkg::KIND_TICK, 24'h5A5A5A);          // nothing pending, no run
    send_item(pru_pkg::KIND_PIXEL, 24'hFFFFFF);
    send_item(pru_pkg::KIND_PIXEL, 24'h000000);

    // two columns at scale three: refused pixel while the replay is pending
    program_register(pru_pkg::REG_SCALE, 3);
    set_width(2);
    send_item(pru_pkg::KIND_PIXEL, 24'h123456);
    send_item(pru_pkg::KIND_PIXEL, 24'hABCDEF);         // closes the row
    send_item(pru_pkg::KIND_PIXEL, 24'hC0FFEE);         // refused
    send_item(pru_pkg::KIND_TICK, random_pixel());

    // scale above the limit saturates, written mid-replay
    program_register(pru_pkg::REG_SCALE, 127);
    send_item(pru_pkg::KIND_TICK, random_pixel());

    // narrower row during the replay ends it at the first column
    set_width(1);
    send_item(pru_pkg::KIND_TICK, random_pixel());
    send_item(pru_pkg::KIND_TICK, random_pixel());      // replay finished, no run

    // zero scale counts as one; width shrunk mid-row closes the row at once
    program_register(pru_pkg::REG_SCALE, 0);
    set_width(3);
    send_item(pru_pkg::KIND_PIXEL, 24'h0F0F0F);
    send_item(pru_pkg::KIND_PIXEL, 24'hF0F0F0);
    set_width(1);
    send_item(pru_pkg::KIND_PIXEL, 24'h00FF00);

    // zero width counts as one column
    program_register(pru_pkg::REG_SCALE, 2);
    set_width(0);
    send_item(pru_pkg::KIND_PIXEL, 24'hA5A5A5);
    send_item(pru_pkg::KIND_TICK, random_pixel());

    // widths at and above the buffer size keep the row open, a shrink then closes it
    program_register(pru_pkg::REG_SCALE, 1);
    set_width(2047);
    repeat (4) send_item(pru_pkg::KIND_PIXEL, random_pixel());
    set_width(1024);
    repeat (4) send_item(pru_pkg::KIND_PIXEL, random_pixel());
    set_width(2);
    send_item(pru_pkg::KIND_PIXEL, random_pixel());

    // random phases of one to three rows each
    random_target = items_sent + RANDOM_ITEMS;
    while (items_sent < random_target) begin
      program_register(pru_pkg::REG_SCALE, pick_scale());
      next_width = pick_width();
      if (scale_in_use(scale_now) * width_in_use(next_width) > ROW_COST_CAP)
        next_width = pru_pkg::COL_W'($urandom_range(2, 1));
      set_width(next_width);
      repeat ($urandom_range(3, 1)) upscale_row();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pru_pkg.sv
sv/pru_ram.sv
sv/pru_ctrl.sv
sv/pru_out.sv
sv/pixel_replicate_upscaler.sv
sim/pru_run_checker.sv
sim/tb_pixel_replicate_upscaler.sv
